[src/intc64_pkg.sv]
// Package for the 64-channel interrupt controller.
// Holds the field widths, mode and register address codes, and the bus and pick structs.
// No dependencies; every other file imports it.
package intc64_pkg;

    // Default channel count, handed to the top level parameter
    localparam int NUM_CHANNELS_DEF = 64;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 6;
    localparam int WORD_W  = 32;
    localparam int LEVEL_W = 64;
    localparam int NUM_W   = 7;

    // Stream widths: tdata padded to whole bytes
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    // Transfer modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Register word addresses
    localparam logic [ADDR_W-1:0] ADDR_STATUS_LO = 6'd0;
    localparam logic [ADDR_W-1:0] ADDR_STATUS_HI = 6'd1;
    localparam logic [ADDR_W-1:0] ADDR_PEND_LO   = 6'd4;
    localparam logic [ADDR_W-1:0] ADDR_PEND_HI   = 6'd5;
    localparam logic [ADDR_W-1:0] ADDR_ENSET_LO  = 6'd8;
    localparam logic [ADDR_W-1:0] ADDR_ENSET_HI  = 6'd9;
    localparam logic [ADDR_W-1:0] ADDR_ENCLR_LO  = 6'd12;
    localparam logic [ADDR_W-1:0] ADDR_ENCLR_HI  = 6'd13;
    localparam logic [ADDR_W-1:0] ADDR_EN_LO     = 6'd16;
    localparam logic [ADDR_W-1:0] ADDR_EN_HI     = 6'd17;
    localparam logic [ADDR_W-1:0] ADDR_MASK_LO   = 6'd20;
    localparam logic [ADDR_W-1:0] ADDR_MASK_HI   = 6'd21;
    localparam logic [ADDR_W-1:0] ADDR_MAP_FIRST = 6'd24;
    localparam logic [ADDR_W-1:0] ADDR_MAP_LAST  = 6'd39;

    // Channel number reported when nothing is active
    localparam logic [NUM_W-1:0] IRQ_NONE = 7'd64;

    // One bus access riding along with a sample
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_bus_req;

    // Outcome of the priority pick
    typedef struct packed {
        logic             line;
        logic [NUM_W-1:0] number;
    } t_irq_pick;

endpackage

[src/intc64_regs.sv]
// Register file of the interrupt controller: enable, mask and source routing,
// pending and final status, and the bus read mux.
// Depends on intc64_pkg.
module intc64_regs #(
    parameter int NUM_CHANNELS = intc64_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_en,
    input  intc64_pkg::t_bus_req               i_req,
    input  logic [intc64_pkg::LEVEL_W-1:0]     i_levels,
    output logic [intc64_pkg::LEVEL_W-1:0]     o_status,
    output logic [intc64_pkg::WORD_W-1:0]      o_rdata
);
    import intc64_pkg::*;

    localparam int MAP_ROWS = (NUM_CHANNELS + 3) / 4;
    localparam int ROW_W    = $clog2(MAP_ROWS);

    logic [NUM_CHANNELS-1:0] r_enable;
    logic [NUM_CHANNELS-1:0] r_mask;
    logic [WORD_W-1:0]       r_map [MAP_ROWS];

    logic [NUM_CHANNELS-1:0] pend;
    logic [LEVEL_W-1:0]      pend64;
    logic [LEVEL_W-1:0]      status64;
    logic [LEVEL_W-1:0]      en64;
    logic [LEVEL_W-1:0]      mask64;
    logic [LEVEL_W-1:0]      w64;
    logic [LEVEL_W-1:0]      half_sel;
    logic                    upper;
    logic                    wr;
    logic                    rd;
    logic                    sel_status, sel_pend, sel_set, sel_clr;
    logic                    sel_en, sel_mask, sel_map;
    logic [ADDR_W-1:0]       map_off;
    logic                    map_ok;
    logic [ROW_W-1:0]        map_idx;
    logic [WORD_W-1:0]       map_word;

    // Route each channel to its source level; 64 and up is disconnected
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_route
        logic [7:0] src;
        assign src     = r_map[c / 4][(c % 4) * 8 +: 8];
        assign pend[c] = (src[7:6] == 2'b00) && i_levels[src[5:0]];
    end

    assign pend64   = LEVEL_W'(pend);
    assign en64     = LEVEL_W'(r_enable);
    assign mask64   = LEVEL_W'(r_mask);
    assign status64 = LEVEL_W'(pend & r_enable & ~r_mask);
    assign o_status = status64;

    assign upper    = i_req.addr[0];
    assign wr       = i_req_en && (i_req.mode == MODE_WRITE);
    assign rd       = (i_req.mode == MODE_READ);
    assign w64      = upper ? {i_req.wdata, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, i_req.wdata};
    assign half_sel = upper ? {{WORD_W{1'b1}}, {WORD_W{1'b0}}}
                            : {{WORD_W{1'b0}}, {WORD_W{1'b1}}};

    assign map_off  = i_req.addr - ADDR_MAP_FIRST;
    assign map_ok   = map_off < ADDR_W'(MAP_ROWS);
    assign map_idx  = map_off[ROW_W-1:0];
    assign map_word = map_ok ? r_map[map_idx] : {WORD_W{1'b1}};

    // Decode the register address
    always_comb begin
        sel_status = 1'b0;
        sel_pend   = 1'b0;
        sel_set    = 1'b0;
        sel_clr    = 1'b0;
        sel_en     = 1'b0;
        sel_mask   = 1'b0;
        sel_map    = 1'b0;
        unique case (i_req.addr) inside
            ADDR_STATUS_LO, ADDR_STATUS_HI: sel_status = 1'b1;
            ADDR_PEND_LO, ADDR_PEND_HI:     sel_pend   = 1'b1;
            ADDR_ENSET_LO, ADDR_ENSET_HI:   sel_set    = 1'b1;
            ADDR_ENCLR_LO, ADDR_ENCLR_HI:   sel_clr    = 1'b1;
            ADDR_EN_LO, ADDR_EN_HI:         sel_en     = 1'b1;
            ADDR_MASK_LO, ADDR_MASK_HI:     sel_mask   = 1'b1;
            [ADDR_MAP_FIRST:ADDR_MAP_LAST]: sel_map    = 1'b1;
            default: ;
        endcase
    end

    // Select read data; zero for anything but a read of a readable word
    always_comb begin
        o_rdata = '0;
        if (rd) begin
            if (sel_status) begin
                o_rdata = upper ? status64[63:32] : status64[31:0];
            end else if (sel_pend) begin
                o_rdata = upper ? pend64[63:32] : pend64[31:0];
            end else if (sel_en) begin
                o_rdata = upper ? en64[63:32] : en64[31:0];
            end else if (sel_mask) begin
                o_rdata = upper ? mask64[63:32] : mask64[31:0];
            end else if (sel_map) begin
                o_rdata = map_word;
            end
        end
    end

    // Enable and mask updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_mask   <= '1;
        end else if (wr) begin
            if (sel_set) begin
                r_enable <= r_enable | w64[NUM_CHANNELS-1:0];
            end else if (sel_clr) begin
                r_enable <= r_enable & ~w64[NUM_CHANNELS-1:0];
            end else if (sel_mask) begin
                r_mask <= (r_mask & ~half_sel[NUM_CHANNELS-1:0]) | w64[NUM_CHANNELS-1:0];
            end
        end
    end

    // Routing bytes; bytes of channels past the last one stay disconnected
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAP_ROWS; r++) begin
                r_map[r] <= '1;
            end
        end else if (wr && sel_map && map_ok) begin
            for (int r = 0; r < MAP_ROWS; r++) begin
                for (int b = 0; b < 4; b++) begin
                    if ((map_idx == ROW_W'(r)) && (r * 4 + b < NUM_CHANNELS)) begin
                        r_map[r][b*8 +: 8] <= i_req.wdata[b*8 +: 8];
                    end
                end
            end
        end
    end

endmodule

[src/intc64_pick.sv]
// Priority pick of the interrupt controller: irq line and chosen channel number
// from the final status word, lowest-first or highest-within-lower-word-first.
// Depends on intc64_pkg.
module intc64_pick (
    input  logic [intc64_pkg::LEVEL_W-1:0] i_status,
    input  logic                           i_order,
    output intc64_pkg::t_irq_pick          o_pick
);
    import intc64_pkg::*;

    // Index of the lowest set bit: isolate it, then OR its index in
    function automatic logic [4:0] low_idx(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] iso;
        logic [4:0]        idx;
        iso = w & (~w + WORD_W'(1));
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            idx = idx | (iso[i] ? 5'(i) : 5'd0);
        end
        return idx;
    endfunction

    logic [WORD_W-1:0] lo, hi, lo_rev, hi_rev;
    logic              lo_any, hi_any;
    logic [4:0]        lo_idx, hi_idx;

    assign lo     = i_status[31:0];
    assign hi     = i_status[63:32];
    assign lo_any = |lo;
    assign hi_any = |hi;
    assign lo_rev = {<<{lo}};
    assign hi_rev = {<<{hi}};

    // Lowest or highest set bit in each half
    assign lo_idx = i_order ? 5'd31 - low_idx(lo_rev) : low_idx(lo);
    assign hi_idx = i_order ? 5'd31 - low_idx(hi_rev) : low_idx(hi);

    // Lower half wins, then upper half, else none
    always_comb begin
        o_pick.line = lo_any || hi_any;
        if (lo_any) begin
            o_pick.number = {2'b00, lo_idx};
        end else if (hi_any) begin
            o_pick.number = {2'b01, hi_idx};
        end else begin
            o_pick.number = IRQ_NONE;
        end
    end

endmodule

[src/interrupt_controller_64_source_top.sv]
// Usage
// Level-sensitive interrupt controller for up to 64 channels.
// Slave stream: one transfer per cycle when s_axis_tready is high carries the 64
// source levels and an optional register access (tuser = mode: sample, read or write).
// Master stream: one transfer per input transfer, carrying the read data,
// the irq line and the chosen channel number (64 when none is active).
// Each channel is routed from a source by a map byte; status is
// pending & enable & ~mask, and the pick order comes from i_cfg_wdata.
// A result reaches the master side through the input register, then the result register.
// Throughput: one transfer per cycle while the master side takes results; all work is
// one pass of routing muxes and the priority encoder between the two registers.
// Register writes take effect for the next transfer.
// Reset: enable bits clear, mask bits set, all channels disconnected, order 0.
// Stall: a full result register that is not taken holds its data; the input
// register still takes a new transfer as long as the result can move on.
// Depends on intc64_pkg, intc64_regs and intc64_pick.
module interrupt_controller_64_source_top #(
    parameter int NUM_CHANNELS = intc64_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [5:0] word_addr, [37:6] write_data, [101:38] source_levels, [103:102] zero
    input  logic [intc64_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] mode
    input  logic [intc64_pkg::MODE_W-1:0]         s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [31:0] read_data, [32] irq_line, [39:33] irq_number
    output logic [intc64_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import intc64_pkg::*;

    logic                   r_order;
    logic                   r_s1_valid;
    t_bus_req               r_s1_req;
    logic [LEVEL_W-1:0]     r_s1_levels;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   out_free;
    logic                   s1_move;
    logic                   in_take;
    t_bus_req               in_req;
    logic [LEVEL_W-1:0]     status;
    logic [WORD_W-1:0]      rdata;
    t_irq_pick              pick;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // Handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Unpack the slave transfer
    assign in_req.mode  = s_axis_tuser;
    assign in_req.addr  = s_axis_tdata[5:0];
    assign in_req.wdata = s_axis_tdata[37:6];

    // Priority order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req    <= in_req;
            r_s1_levels <= s_axis_tdata[101:38];
        end
    end

    intc64_regs #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_en (s1_move),
        .i_req    (r_s1_req),
        .i_levels (r_s1_levels),
        .o_status (status),
        .o_rdata  (rdata)
    );

    intc64_pick u_pick (
        .i_status (status),
        .i_order  (r_order),
        .o_pick   (pick)
    );

    assign n_out_data = {pick.number, pick.line, rdata};

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[src/intc64_chk.sv]
// Port-level checker for the interrupt controller top level, and its bind.
// Depends on intc64_pkg; attaches to interrupt_controller_64_source_top.
module intc64_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [intc64_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import intc64_pkg::*;

    logic             irq_line;
    logic [NUM_W-1:0] irq_number;

    assign irq_line   = m_axis_tdata[32];
    assign irq_number = m_axis_tdata[39:33];

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Line and number agree
    a_line_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (irq_line == (irq_number != IRQ_NONE)))
        else $error("irq line and number disagree");

    // Number never past the no-interrupt code
    a_number_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (irq_number <= IRQ_NONE))
        else $error("irq number out of range");

    // Empty result side never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind interrupt_controller_64_source_top intc64_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
